### hw/rtl/mfe_pkg.sv
// Shared types and constants for the motor feedback estimator.
// Pure declarations; no dependencies.
package mfe_pkg;

  // Encoder count
  localparam int unsigned CNT_W = 14;
  localparam int unsigned OFS_W = 14;
  localparam logic [OFS_W-1:0] OFS1_RESET = 14'd7226;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [0:0] {
    REG_OFFSET_M0 = 1'b0,
    REG_OFFSET_M1 = 1'b1
  } reg_idx_t;

  // Angle conversion: round(x * 6.28 / 4) done as (x*157 + 50) / 100, with the
  // divide by 100 folded into a reciprocal M = ceil(2^29 / 100), exact for
  // every numerator below 2^22.
  localparam int unsigned ANG_SHIFT = 29;
  localparam int unsigned ANG_PROD_W = 44;
  localparam logic [31:0] MECH_MUL = 32'd842887470;   // 157 * M
  localparam logic [31:0] ELEC_MUL = 32'd3371549880;  // 628 * M
  localparam logic [31:0] ANG_RND = 32'd268435500;    // 50 * M
  localparam int unsigned ANG_W = 15;
  localparam int unsigned ELEC_CNT_W = 12;

  // Speed: count step to Q8 rad/s is d * 3925 / 4, EMA alpha 1/128
  localparam int unsigned SPD_W = 24;
  localparam int unsigned FILT_W = 25;
  localparam int unsigned SPD_PROD_W = 27;
  localparam logic [12:0] SPEED_GAIN = 13'd3925;
  localparam int unsigned EMA_SHIFT = 7;

  // Phase current output
  localparam int unsigned CUR_W = 14;

endpackage

### hw/rtl/motor_feedback_estimator_core.sv
// Motor feedback estimator: encoder position, angles, filtered speed and
// phase currents per sample set. Depends on mfe_pkg.
//
//  channel  | handshake                     | contents
//  ---------+-------------------------------+-----------------------------------------
//  in       | in_valid / in_stall           | motor, encoder_word, adc_a/b/c
//  out      | out_valid / out_stall         | motor_out, position_count, mech_angle,
//           |                               | elec_phase, speed, current_a/b/c
//  cfg      | psel/penable/pwrite, pready=1 | encoder_offset_motor0/1 at 0x0 / 0x4
//
// One request per cycle while in_stall is low; the result is registered: all arithmetic
// sits between the input ports and the output register, and the per-motor speed state
// is read, updated and written back in the cycle a request is taken.
// Synchronous active-high reset clears the speed state and the output valid
// and loads the offset registers with their defaults (motor 1: 7226).
// in_stall rises only while a result is held and out_stall is high; a result
// being taken in the same cycle frees the register for the next request.
module motor_feedback_estimator_core #(
  parameter int ADC_BITS = 12,
  parameter int NUM_MOTORS = 2
) (
  input  logic clk,
  input  logic rst,

  // input channel
  input  logic in_valid,
  output logic in_stall,
  input  logic motor,
  input  logic [15:0] encoder_word,
  input  logic [ADC_BITS-1:0] adc_a,
  input  logic [ADC_BITS-1:0] adc_b,
  input  logic [ADC_BITS-1:0] adc_c,

  // output channel
  output logic out_valid,
  input  logic out_stall,
  output logic motor_out,
  output logic [mfe_pkg::CNT_W-1:0] position_count,
  output logic [mfe_pkg::ANG_W-1:0] mech_angle,
  output logic [mfe_pkg::ANG_W-1:0] elec_phase,
  output logic signed [mfe_pkg::SPD_W-1:0] speed,
  output logic signed [mfe_pkg::CUR_W-1:0] current_a,
  output logic signed [mfe_pkg::CUR_W-1:0] current_b,
  output logic signed [mfe_pkg::CUR_W-1:0] current_c,

  // configuration port
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [mfe_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mfe_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mfe_pkg::APB_DATA_W-1:0] prdata,
  output logic pready
);

  // Only two motor indexes can be addressed; a single-motor build folds both
  // onto entry zero.
  localparam int STATE_DEPTH = (NUM_MOTORS > 1) ? 2 : 1;
  localparam int SUM_W = (ADC_BITS + 3 > mfe_pkg::CUR_W) ? ADC_BITS + 3 : mfe_pkg::CUR_W;
  localparam logic [mfe_pkg::OFS_W-1:0] OFS1_INIT =
      (NUM_MOTORS > 1) ? mfe_pkg::OFS1_RESET : '0;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [mfe_pkg::OFS_W-1:0] offset0;
  logic [mfe_pkg::OFS_W-1:0] offset1;
  logic cfg_wr;
  mfe_pkg::reg_idx_t cfg_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign cfg_idx = mfe_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      offset0 <= '0;
      offset1 <= OFS1_INIT;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        mfe_pkg::REG_OFFSET_M0: offset0 <= pwdata[mfe_pkg::OFS_W-1:0];
        mfe_pkg::REG_OFFSET_M1: begin
          // Motor 1 has no offset in a single-motor build: drop the write.
          if (NUM_MOTORS > 1) offset1 <= pwdata[mfe_pkg::OFS_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      mfe_pkg::REG_OFFSET_M0: prdata = {{(mfe_pkg::APB_DATA_W-mfe_pkg::OFS_W){1'b0}}, offset0};
      mfe_pkg::REG_OFFSET_M1: prdata = {{(mfe_pkg::APB_DATA_W-mfe_pkg::OFS_W){1'b0}}, offset1};
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: one output register; take a request whenever it is empty or
  // being drained this cycle.
  // ---------------------------------------------------------------------------
  logic in_take;

  assign in_stall = out_valid & out_stall;
  assign in_take = in_valid & ~in_stall;

  // ---------------------------------------------------------------------------
  // Position count
  // ---------------------------------------------------------------------------
  logic m_idx;
  logic [mfe_pkg::OFS_W-1:0] offset_sel;
  logic [mfe_pkg::CNT_W-1:0] count;

  assign m_idx = (STATE_DEPTH > 1) ? motor : 1'b0;
  assign offset_sel = m_idx ? offset1 : offset0;
  assign count = encoder_word[mfe_pkg::CNT_W-1:0] + offset_sel;

  // ---------------------------------------------------------------------------
  // Angles: one constant multiply each, reciprocal divide folded in
  // ---------------------------------------------------------------------------
  logic [mfe_pkg::ANG_PROD_W-1:0] mech_prod;
  logic [mfe_pkg::ANG_PROD_W-1:0] elec_prod;
  logic [mfe_pkg::ANG_W-1:0] mech_q;
  logic [mfe_pkg::ANG_W-1:0] elec_q;

  assign mech_prod = mfe_pkg::ANG_PROD_W'(count) * mfe_pkg::ANG_PROD_W'(mfe_pkg::MECH_MUL)
                   + mfe_pkg::ANG_PROD_W'(mfe_pkg::ANG_RND);
  assign elec_prod = mfe_pkg::ANG_PROD_W'(count[mfe_pkg::ELEC_CNT_W-1:0])
                       * mfe_pkg::ANG_PROD_W'(mfe_pkg::ELEC_MUL)
                   + mfe_pkg::ANG_PROD_W'(mfe_pkg::ANG_RND);
  assign mech_q = mech_prod[mfe_pkg::ANG_SHIFT +: mfe_pkg::ANG_W];
  assign elec_q = elec_prod[mfe_pkg::ANG_SHIFT +: mfe_pkg::ANG_W];

  // ---------------------------------------------------------------------------
  // Speed: wrapped count step, scale, EMA
  // ---------------------------------------------------------------------------
  logic [mfe_pkg::CNT_W-1:0] last_count [STATE_DEPTH];
  logic signed [mfe_pkg::FILT_W-1:0] filtered_speed [STATE_DEPTH];

  logic signed [mfe_pkg::CNT_W-1:0] step_d;
  logic signed [mfe_pkg::SPD_PROD_W-1:0] spd_prod;
  logic signed [mfe_pkg::FILT_W-1:0] raw_speed;
  logic signed [mfe_pkg::FILT_W:0] ema_err;
  logic signed [mfe_pkg::FILT_W-mfe_pkg::EMA_SHIFT:0] ema_step;
  logic signed [mfe_pkg::FILT_W-1:0] filt_cur;
  logic signed [mfe_pkg::FILT_W-1:0] filt_next;

  // The 14-bit difference read as signed is the step wrapped into -8192..8191.
  assign step_d = $signed(count - last_count[m_idx]);
  assign spd_prod = $signed({{(mfe_pkg::SPD_PROD_W-mfe_pkg::CNT_W){step_d[mfe_pkg::CNT_W-1]}},
                             step_d})
                  * $signed({{(mfe_pkg::SPD_PROD_W-13){1'b0}}, mfe_pkg::SPEED_GAIN});
  // Dropping the two low bits of a two's complement value rounds toward minus infinity.
  assign raw_speed = spd_prod[mfe_pkg::SPD_PROD_W-1:2];
  assign filt_cur = filtered_speed[m_idx];
  assign ema_err = $signed({raw_speed[mfe_pkg::FILT_W-1], raw_speed})
                 - $signed({filt_cur[mfe_pkg::FILT_W-1], filt_cur});
  assign ema_step = ema_err[mfe_pkg::FILT_W:mfe_pkg::EMA_SHIFT];
  assign filt_next = filt_cur
                   + $signed({{(mfe_pkg::EMA_SHIFT-1){ema_step[mfe_pkg::FILT_W-mfe_pkg::EMA_SHIFT]}},
                              ema_step});

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STATE_DEPTH; i++) begin
        last_count[i] <= '0;
        filtered_speed[i] <= '0;
      end
    end else if (in_take) begin
      last_count[m_idx] <= count;
      filtered_speed[m_idx] <= filt_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Phase currents: 2x - y - z on the zero-extended samples
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sa;
  logic signed [SUM_W-1:0] sb;
  logic signed [SUM_W-1:0] sc;
  logic signed [SUM_W-1:0] cur_a;
  logic signed [SUM_W-1:0] cur_b;
  logic signed [SUM_W-1:0] cur_c;

  assign sa = $signed({{(SUM_W-ADC_BITS){1'b0}}, adc_a});
  assign sb = $signed({{(SUM_W-ADC_BITS){1'b0}}, adc_b});
  assign sc = $signed({{(SUM_W-ADC_BITS){1'b0}}, adc_c});
  assign cur_a = (sa <<< 1) - sb - sc;
  assign cur_b = (sb <<< 1) - sc - sa;
  assign cur_c = (sc <<< 1) - sa - sb;

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      motor_out <= motor;
      position_count <= count;
      mech_angle <= mech_q;
      elec_phase <= elec_q;
      speed <= filt_next[mfe_pkg::SPD_W-1:0];
      current_a <= cur_a[mfe_pkg::CUR_W-1:0];
      current_b <= cur_b[mfe_pkg::CUR_W-1:0];
      current_c <= cur_c[mfe_pkg::CUR_W-1:0];
    end
  end

endmodule

### verif/motor_feedback_estimator_core_tb.sv
// Testbench for motor_feedback_estimator_core: random and directed sample sets with
// an in-order scoreboard and APB offset writes. Depends on mfe_pkg and the core.
`timescale 1ns / 100ps

module motor_feedback_estimator_core_tb;

  localparam int CLK_HALF = 5;
  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 300;

  // One sample set as offered on the input channel
  typedef struct packed {
    logic        motor;
    logic [15:0] encoder_word;
    logic [11:0] adc_a;
    logic [11:0] adc_b;
    logic [11:0] adc_c;
  } sample_t;

  // One feedback result as seen on the output channel
  typedef struct packed {
    logic                      motor;
    logic [mfe_pkg::CNT_W-1:0] position;
    logic [mfe_pkg::ANG_W-1:0] mech;
    logic [mfe_pkg::ANG_W-1:0] elec;
    logic [mfe_pkg::SPD_W-1:0] speed;
    logic [mfe_pkg::CUR_W-1:0] cur_a;
    logic [mfe_pkg::CUR_W-1:0] cur_b;
    logic [mfe_pkg::CUR_W-1:0] cur_c;
  } feedback_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        motor = 1'b0;
  logic [15:0] encoder_word = '0;
  logic [11:0] adc_a = '0;
  logic [11:0] adc_b = '0;
  logic [11:0] adc_c = '0;

  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             motor_out;
  logic [mfe_pkg::CNT_W-1:0]        position_count;
  logic [mfe_pkg::ANG_W-1:0]        mech_angle;
  logic [mfe_pkg::ANG_W-1:0]        elec_phase;
  logic signed [mfe_pkg::SPD_W-1:0] speed;
  logic signed [mfe_pkg::CUR_W-1:0] current_a;
  logic signed [mfe_pkg::CUR_W-1:0] current_b;
  logic signed [mfe_pkg::CUR_W-1:0] current_c;

  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [mfe_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [mfe_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [mfe_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  motor_feedback_estimator_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .motor(motor),
    .encoder_word(encoder_word), .adc_a(adc_a), .adc_b(adc_b), .adc_c(adc_c),
    .out_valid(out_valid), .out_stall(out_stall), .motor_out(motor_out),
    .position_count(position_count), .mech_angle(mech_angle),
    .elec_phase(elec_phase), .speed(speed),
    .current_a(current_a), .current_b(current_b), .current_c(current_c),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #CLK_HALF clk = ~clk;

  // Requests waiting to be offered, and feedback predicted for accepted requests
  sample_t   pending_samples[$];
  feedback_t expected_feedback[$];

  // Predictor copy of the offset registers and the per-motor speed state
  logic [mfe_pkg::CNT_W-1:0] offset_model[2];
  logic [mfe_pkg::CNT_W-1:0] last_count_model[2];
  longint                    filt_speed_model[2];

  // Stimulus knobs, set by the sequencer at a rising edge; hold_cycles also counts down
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  // Encoder positions of the simulated rotation, per motor
  int rotor_pos[2] = '{0, 0};

  int n_errors = 0;
  int n_cycles = 0;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    n_errors++;
  endtask

  // Work out the feedback for one accepted request and advance the speed state.
  function automatic feedback_t predict_feedback(sample_t s);
    feedback_t                 fb;
    int                        m;
    logic [mfe_pkg::CNT_W-1:0] cnt;
    longint                    c, d, raw, a, b, cc;
    m   = int'(s.motor);
    cnt = s.encoder_word[mfe_pkg::CNT_W-1:0] + offset_model[m];
    c   = longint'(cnt);
    d   = ((c + 24576 - longint'(last_count_model[m])) & 16'h3FFF) - 8192;
    raw = (d * 3925) >>> 2;
    filt_speed_model[m] += (raw - filt_speed_model[m]) >>> mfe_pkg::EMA_SHIFT;
    last_count_model[m] = cnt;
    a  = longint'(s.adc_a);
    b  = longint'(s.adc_b);
    cc = longint'(s.adc_c);
    fb.motor    = s.motor;
    fb.position = cnt;
    fb.mech     = mfe_pkg::ANG_W'((c * 157 + 50) / 100);
    fb.elec     = mfe_pkg::ANG_W'(((c & 12'hFFF) * 628 + 50) / 100);
    fb.speed    = mfe_pkg::SPD_W'(filt_speed_model[m]);
    fb.cur_a    = mfe_pkg::CUR_W'(2 * a - b - cc);
    fb.cur_b    = mfe_pkg::CUR_W'(2 * b - cc - a);
    fb.cur_c    = mfe_pkg::CUR_W'(2 * cc - a - b);
    return fb;
  endfunction

  // Driver: predict on acceptance, then offer the next request or go idle.
  // A held request stays on the ports untouched while in_stall is high.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_feedback.push_back(
          predict_feedback({motor, encoder_word, adc_a, adc_b, adc_c}));
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_t s;
          s = pending_samples.pop_front();
          in_valid     <= 1'b1;
          motor        <= s.motor;
          encoder_word <= s.encoder_word;
          adc_a        <= s.adc_a;
          adc_b        <= s.adc_b;
          adc_c        <= s.adc_c;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every taken result with the oldest prediction, then
  // register the stall (random, or forced by a running hold-off).
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_feedback.size() == 0) begin
          report_mismatch("unexpected result, motor_out", motor_out, -1);
        end else begin
          feedback_t want;
          want = expected_feedback.pop_front();
          if (motor_out !== want.motor)
            report_mismatch("motor_out", motor_out, want.motor);
          if (position_count !== want.position)
            report_mismatch("position_count", position_count, want.position);
          if (mech_angle !== want.mech)
            report_mismatch("mech_angle", mech_angle, want.mech);
          if (elec_phase !== want.elec)
            report_mismatch("elec_phase", elec_phase, want.elec);
          if (speed !== want.speed)
            report_mismatch("speed", speed, $signed(want.speed));
          if (current_a !== want.cur_a)
            report_mismatch("current_a", current_a, $signed(want.cur_a));
          if (current_b !== want.cur_b)
            report_mismatch("current_b", current_b, $signed(want.cur_b));
          if (current_c !== want.cur_c)
            report_mismatch("current_c", current_c, $signed(want.cur_c));
        end
      end
      out_stall <= (hold_cycles != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Count down a receiver hold-off; the sequencer only arms it while it is zero.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // Watchdog on the whole run
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("[%0t] timeout with %0d results outstanding", $time,
               expected_feedback.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_sample(logic m, logic [15:0] word, logic [11:0] a, logic [11:0] b,
                              logic [11:0] c);
    pending_samples.push_back({m, word, a, b, c});
  endtask

  // Mostly uniform converter samples, with the rails now and then.
  function automatic logic [11:0] random_adc();
    case ($urandom_range(7))
      0: return 12'h000;
      1: return 12'hFFF;
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  // Per-run count step: the wrap extremes, standstill, slow and arbitrary.
  function automatic int pick_step();
    case ($urandom_range(5))
      0: return 8191;
      1: return -8192;
      2: return 0;
      3: return int'($urandom_range(400)) - 200;
      default: return int'($urandom_range(16383)) - 8192;
    endcase
  endfunction

  // Fill the request queue: mostly steady rotation runs so the filter
  // settles toward real speeds, with bursts of arbitrary encoder words.
  task automatic queue_random_items(int n);
    int step[2];
    int len;
    int m;
    while (n > 0) begin
      if ($urandom_range(9) < 8) begin
        step[0] = pick_step();
        step[1] = pick_step();
        len = $urandom_range(40, 8);
        for (int i = 0; i < len && n > 0; i++) begin
          m = $urandom_range(1);
          rotor_pos[m] = (rotor_pos[m] + step[m]) & 16'h3FFF;
          queue_sample(1'(m), {2'($urandom_range(3)), 14'(rotor_pos[m])},
                       random_adc(), random_adc(), random_adc());
          n--;
        end
      end else begin
        len = $urandom_range(6, 1);
        for (int i = 0; i < len && n > 0; i++) begin
          queue_sample(1'($urandom_range(1)), 16'($urandom_range(65535)),
                       random_adc(), random_adc(), random_adc());
          n--;
        end
      end
    end
  endtask

  // Wait until every queued request has been accepted and has produced its result.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_feedback.size() != 0);
  endtask

  task automatic write_offset(mfe_pkg::reg_idx_t idx, logic [mfe_pkg::APB_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // The register took the value at this edge
    offset_model[idx] = value[mfe_pkg::CNT_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_offset(mfe_pkg::reg_idx_t idx);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (pready !== 1'b1 || prdata !== mfe_pkg::APB_DATA_W'(offset_model[idx]))
      report_mismatch(idx == mfe_pkg::REG_OFFSET_M0 ? "offset read motor0"
                                                    : "offset read motor1",
                      prdata, offset_model[idx]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int n);
    @(posedge clk);
    send_idle_pct  <= idle_pct;
    recv_stall_pct <= stall_pct;
    queue_random_items(n);
    wait_drained();
  endtask

  initial begin
    offset_model[mfe_pkg::REG_OFFSET_M0] = '0;
    offset_model[mfe_pkg::REG_OFFSET_M1] = mfe_pkg::OFS1_RESET;
    last_count_model = '{default: '0};
    filt_speed_model = '{default: 0};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults of the offsets read back first
    check_offset(mfe_pkg::REG_OFFSET_M0);
    check_offset(mfe_pkg::REG_OFFSET_M1);

    // Directed: first sample after reset sees the jump from count zero,
    // the step wraps at +8191 / -8192 / +-1, current rails on each phase,
    // upper encoder bits that must be masked off.
    queue_sample(1'b0, 16'h0000, 12'h000, 12'h000, 12'h000);
    queue_sample(1'b0, 16'hDFFF, 12'hFFF, 12'h000, 12'h000);
    queue_sample(1'b0, 16'h3FFF, 12'h000, 12'hFFF, 12'hFFF);
    queue_sample(1'b0, 16'h4000, 12'h000, 12'hFFF, 12'h000);
    queue_sample(1'b0, 16'hFFFF, 12'h000, 12'h000, 12'hFFF);
    queue_sample(1'b0, 16'h8FFF, 12'hFFF, 12'hFFF, 12'h000);
    queue_sample(1'b1, 16'h0000, 12'hFFF, 12'hFFF, 12'hFFF);
    queue_sample(1'b1, 16'hC000, 12'hFFF, 12'h000, 12'hFFF);
    queue_sample(1'b1, 16'h7FFF, 12'h000, 12'hFFF, 12'hFFF);
    wait_drained();

    // Offset extremes; pwdata upper bits must be dropped
    write_offset(mfe_pkg::REG_OFFSET_M0, 32'hFFFF_FFFF);
    write_offset(mfe_pkg::REG_OFFSET_M1, 32'hFFFF_C000);
    check_offset(mfe_pkg::REG_OFFSET_M0);
    check_offset(mfe_pkg::REG_OFFSET_M1);
    queue_sample(1'b0, 16'h0001, 12'h800, 12'h7FF, 12'h001);
    queue_sample(1'b0, 16'h0000, 12'h001, 12'h800, 12'h7FF);
    queue_sample(1'b0, 16'h1000, 12'h555, 12'hAAA, 12'h000);
    queue_sample(1'b1, 16'h3FFF, 12'hAAA, 12'h555, 12'hFFF);
    queue_sample(1'b1, 16'h0FFF, 12'h000, 12'h000, 12'h000);
    queue_sample(1'b1, 16'h3000, 12'hFFF, 12'hFFF, 12'hFFF);
    wait_drained();

    // Random phases: no idling, sender idling, receiver stalling, both
    run_phase(0, 0, 120);
    write_offset(mfe_pkg::REG_OFFSET_M0, $urandom());
    write_offset(mfe_pkg::REG_OFFSET_M1, $urandom());
    run_phase(64, 0, 120);
    write_offset(mfe_pkg::REG_OFFSET_M1, 32'h0000_0000);
    check_offset(mfe_pkg::REG_OFFSET_M1);
    run_phase(0, 64, 120);
    write_offset(mfe_pkg::REG_OFFSET_M0, 32'h0000_0000);
    write_offset(mfe_pkg::REG_OFFSET_M1, 32'(mfe_pkg::OFS1_RESET));
    check_offset(mfe_pkg::REG_OFFSET_M0);
    run_phase(33, 33, 120);

    // Long receiver hold-off while the sender keeps offering, so the output
    // register fills and in_stall backs up onto the input channel
    write_offset(mfe_pkg::REG_OFFSET_M0, $urandom());
    @(posedge clk);
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    hold_cycles    <= HOLD_OFF_CYCLES;
    queue_random_items(40);
    wait_drained();

    // Let any late result surface before the verdict
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/mfe_pkg.sv
hw/rtl/motor_feedback_estimator_core.sv
verif/motor_feedback_estimator_core_tb.sv
